// ----- rtl/eq_pkg.sv -----
package eq_pkg;

  // CORDIC working widths: x and y in Q1.31 with headroom, z in 2^33 units per turn.
  localparam int X_W = 34;
  localparam int Z_W = 35;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // CORDIC gain K in Q1.31.
  localparam logic signed [X_W-1:0] GAIN = 34'sh04DBA76D4;

  // round(atan(2^-i) * 2^32 / (2*pi))
  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

// ----- rtl/euler_to_quaternion_core.sv -----
// The queue head feeds the first CORDIC step directly, then one register per CORDIC step,
// then rounding, two multiply stages with a rounding stage between, and the output register.
// Throughput: one item per cycle; the pipeline stalls as a whole when the output waits.
// Reset clears the input queue and the pipeline valid bits; no data state is kept.
module euler_to_quaternion_core #(
  parameter int ANGLE_BITS   = 16,
  parameter int FRAC_BITS    = 15,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // heading [15:0], attitude [31:16], bank [47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // qw [15:0], qx [31:16], qy [47:32], qz [63:48]
);

  logic q_valid, q_ready;
  logic [3*eq_pkg::Z_W-1:0] q_data;

  eq_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  eq_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- rtl/eq_front.sv -----
module eq_front #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [47:0]                 s_tdata,  // heading, attitude, bank
  output logic                        q_valid,
  input  logic                        q_ready,
  output logic [3*eq_pkg::Z_W-1:0]    q_data    // z of heading, attitude, bank
);

  logic [3*eq_pkg::Z_W-1:0] mem [eq_pkg::QDEPTH];
  logic [eq_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [eq_pkg::QCNT_W-1:0] count;
  logic [3*eq_pkg::Z_W-1:0] z_all;
  logic push, pop;

  // Keep the low ANGLE_BITS of each field as a signed angle and scale it to
  // the accumulator's units; this is the half angle.
  for (genvar a = 0; a < 3; a++) begin : g_ang
    logic [31:0] raw;
    logic signed [ANGLE_BITS-1:0] ang;
    assign raw = {16'b0, s_tdata[16*a +: 16]};
    assign ang = raw[ANGLE_BITS-1:0];
    assign z_all[eq_pkg::Z_W*a +: eq_pkg::Z_W] =
      eq_pkg::Z_W'(ang) <<< (32 - ANGLE_BITS);
  end

  assign s_tready = (count != eq_pkg::QCNT_W'(eq_pkg::QDEPTH));
  assign push = s_tvalid && s_tready;
  assign q_valid = (count != '0);
  assign pop = q_valid && q_ready;
  assign q_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= z_all;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + eq_pkg::QCNT_W'(push) - eq_pkg::QCNT_W'(pop);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= eq_pkg::QCNT_W'(eq_pkg::QDEPTH)) else $error("queue overfilled");
  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("queue count lost a push");

endmodule

// ----- rtl/eq_cordic.sv -----
module eq_cordic #(
  parameter int FRAC_BITS    = 15,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [eq_pkg::Z_W-1:0]  z_in,
  output logic signed [FRAC_BITS:0]      sin_q,
  output logic signed [FRAC_BITS:0]      cos_q
);

  localparam int XW = eq_pkg::X_W;
  localparam int SH = 31 - FRAC_BITS;
  localparam logic signed [XW-1:0] RND =
    (SH == 0) ? '0 : XW'(64'sd1 <<< ((SH == 0) ? 0 : SH - 1));
  localparam logic signed [XW-1:0] LIM = XW'((64'sd1 <<< FRAC_BITS) - 1);

  logic signed [XW-1:0] xs [CORDIC_STEPS+1];
  logic signed [XW-1:0] ys [CORDIC_STEPS+1];
  logic signed [eq_pkg::Z_W-1:0] zs [CORDIC_STEPS+1];
  logic signed [XW-1:0] xr, yr;

  assign xs[0] = eq_pkg::GAIN;
  assign ys[0] = '0;
  assign zs[0] = z_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [eq_pkg::Z_W-1:0] DA =
      eq_pkg::Z_W'({eq_pkg::ATAN_TURN[i], 1'b0});
    always_ff @(posedge clk) begin
      if (en) begin
        // A zero residual rotates in the positive direction.
        if (!zs[i][eq_pkg::Z_W-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - DA;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + DA;
        end
      end
    end
  end

  always_comb begin
    xr = (xs[CORDIC_STEPS] + RND) >>> SH;
    yr = (ys[CORDIC_STEPS] + RND) >>> SH;
    if (xr > LIM) xr = LIM;
    else if (xr < -LIM) xr = -LIM;
    if (yr > LIM) yr = LIM;
    else if (yr < -LIM) yr = -LIM;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= xr[FRAC_BITS:0];
      sin_q <= yr[FRAC_BITS:0];
    end
  end

endmodule

// ----- rtl/eq_back.sv -----
module eq_back #(
  parameter int FRAC_BITS    = 15,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  logic [3*eq_pkg::Z_W-1:0]    q_data,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [63:0]                 m_tdata   // qw, qx, qy, qz
);

  localparam int CW = FRAC_BITS + 1;   // sine, cosine
  localparam int PW = 2 * CW;          // pair product
  localparam int RW = CW + 1;          // rounded pair
  localparam int MW = RW + CW;         // second product
  localparam int SW = MW + 1;          // sum
  localparam int LAT = CORDIC_STEPS + 5;
  localparam logic signed [PW-1:0] RNDP = PW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] RNDS = SW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] ONE  = SW'(64'sd1 <<< FRAC_BITS);

  logic en;
  logic [LAT-1:0] vld;
  logic signed [CW-1:0] sn [3];
  logic signed [CW-1:0] cs [3];

  // Whole pipeline advances together; the last stage is the output register.
  assign en = !vld[LAT-1] || m_tready;
  assign q_ready = en;
  assign m_tvalid = vld[LAT-1];

  for (genvar a = 0; a < 3; a++) begin : g_cordic
    eq_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clk   (clk),
      .en    (en),
      .z_in  (q_data[eq_pkg::Z_W*a +: eq_pkg::Z_W]),
      .sin_q (sn[a]),
      .cos_q (cs[a])
    );
  end

  // Pair products, then rounded pairs, then the eight second products.
  logic signed [PW-1:0] p_c1c2, p_s1s2, p_s1c2, p_c1s2;
  logic signed [CW-1:0] p_s3, p_c3, r_s3, r_c3;
  logic signed [RW-1:0] r_c1c2, r_s1s2, r_s1c2, r_c1s2;
  logic signed [PW-1:0] t_c1c2, t_s1s2, t_s1c2, t_c1s2;
  logic signed [MW-1:0] m_wa, m_wb, m_xa, m_xb, m_ya, m_yb, m_za, m_zb;
  logic signed [SW-1:0] f_w, f_x, f_y, f_z;
  logic [15:0] qw, qx, qy, qz;

  always_comb begin
    t_c1c2 = (p_c1c2 + RNDP) >>> FRAC_BITS;
    t_s1s2 = (p_s1s2 + RNDP) >>> FRAC_BITS;
    t_s1c2 = (p_s1c2 + RNDP) >>> FRAC_BITS;
    t_c1s2 = (p_c1s2 + RNDP) >>> FRAC_BITS;
    f_w = (SW'(m_wa) - SW'(m_wb) + RNDS) >>> FRAC_BITS;
    f_x = (SW'(m_xa) + SW'(m_xb) + RNDS) >>> FRAC_BITS;
    f_y = (SW'(m_ya) + SW'(m_yb) + RNDS) >>> FRAC_BITS;
    f_z = (SW'(m_za) - SW'(m_zb) + RNDS) >>> FRAC_BITS;
    if (f_w > ONE - 1) f_w = ONE - 1; else if (f_w < -ONE) f_w = -ONE;
    if (f_x > ONE - 1) f_x = ONE - 1; else if (f_x < -ONE) f_x = -ONE;
    if (f_y > ONE - 1) f_y = ONE - 1; else if (f_y < -ONE) f_y = -ONE;
    if (f_z > ONE - 1) f_z = ONE - 1; else if (f_z < -ONE) f_z = -ONE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_c1c2 <= cs[0] * cs[1];
      p_s1s2 <= sn[0] * sn[1];
      p_s1c2 <= sn[0] * cs[1];
      p_c1s2 <= cs[0] * sn[1];
      p_s3   <= sn[2];
      p_c3   <= cs[2];
      r_c1c2 <= t_c1c2[RW-1:0];
      r_s1s2 <= t_s1s2[RW-1:0];
      r_s1c2 <= t_s1c2[RW-1:0];
      r_c1s2 <= t_c1s2[RW-1:0];
      r_s3   <= p_s3;
      r_c3   <= p_c3;
      m_wa <= r_c1c2 * r_c3;
      m_wb <= r_s1s2 * r_s3;
      m_xa <= r_c1c2 * r_s3;
      m_xb <= r_s1s2 * r_c3;
      m_ya <= r_s1c2 * r_c3;
      m_yb <= r_c1s2 * r_s3;
      m_za <= r_c1s2 * r_c3;
      m_zb <= r_s1c2 * r_s3;
      qw <= f_w[15:0];
      qx <= f_x[15:0];
      qy <= f_y[15:0];
      qz <= f_z[15:0];
    end
  end

  assign m_tdata = {qz, qy, qx, qw};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], q_valid};
    end
  end

  a_vld_entry: assert property (@(posedge clk) disable iff (rst)
    en |=> vld[0] == $past(q_valid)) else $error("pipeline entry lost a transfer");
  a_vld_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld)) else $error("pipeline moved while stalled");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [15:0] bank;
    logic [15:0] attitude;
    logic [15:0] heading;
  } angles_t;

  typedef struct packed {
    logic [15:0] qz;
    logic [15:0] qy;
    logic [15:0] qx;
    logic [15:0] qw;
  } quat_t;

  typedef struct {
    angles_t ang;
    bit      drain_first;
  } angle_item_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // heading [15:0], attitude [31:16], bank [47:32]
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // qw [15:0], qx [31:16], qy [47:32], qz [63:48]

  angle_item_t angle_queue[$];
  quat_t       quat_expected[$];
  int          error_count;
  int          send_gap;
  int          recv_gap;
  int          calm_cycles;

  euler_to_quaternion_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Sine and cosine of half a binary angle, Q1.15.
  function automatic void half_angle_sincos(input logic [15:0] a, output longint sn,
                                            output longint cs);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    longint da;
    z = longint'($signed(a)) * 65536;
    x = longint'(eq_pkg::GAIN);
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      da = 2 * longint'(eq_pkg::ATAN_TURN[i]);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - da;
      end else begin
        x = x + dx; y = y - dy; z = z + da;
      end
    end
    cs = clamp(round_half_up(x, 16), -32767, 32767);
    sn = clamp(round_half_up(y, 16), -32767, 32767);
  endfunction

  function automatic logic [15:0] quat_component(longint sum);
    longint r;
    r = clamp(round_half_up(sum, 15), -32768, 32767);
    return r[15:0];
  endfunction

  function automatic quat_t euler_to_quat(angles_t ang);
    longint s1, c1, s2, c2, s3, c3;
    longint c1c2, s1s2, s1c2, c1s2;
    quat_t q;
    half_angle_sincos(ang.heading, s1, c1);
    half_angle_sincos(ang.attitude, s2, c2);
    half_angle_sincos(ang.bank, s3, c3);
    c1c2 = round_half_up(c1 * c2, 15);
    s1s2 = round_half_up(s1 * s2, 15);
    s1c2 = round_half_up(s1 * c2, 15);
    c1s2 = round_half_up(c1 * s2, 15);
    q.qw = quat_component(c1c2 * c3 - s1s2 * s3);
    q.qx = quat_component(c1c2 * s3 + s1s2 * c3);
    q.qy = quat_component(s1c2 * c3 + c1s2 * s3);
    q.qz = quat_component(c1s2 * c3 - s1c2 * s3);
    return q;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(16'h0000 + $urandom_range(0, 3));
      3: return 16'(16'hFFFF - $urandom_range(0, 3));
      4: return 16'(16'h4000 + $urandom_range(0, 2) - 1);
      5: return 16'(16'hC000 + $urandom_range(0, 2) - 1);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_angles(logic [15:0] h, logic [15:0] a, logic [15:0] b, bit drain);
    angle_item_t it;
    it.ang.heading = h;
    it.ang.attitude = a;
    it.ang.bank = b;
    it.drain_first = drain;
    angle_queue.push_back(it);
  endtask

  // Driver: one nonblocking assignment per signal per edge.
  always @(posedge clk) begin
    bit next_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        quat_expected.push_back(euler_to_quat(angles_t'(s_tdata)));
      end
      next_valid = s_tvalid && !s_tready;
      if (!next_valid) begin
        if (send_gap > 0 && calm_cycles == 0) begin
          send_gap <= send_gap - 1;
        end else if (angle_queue.size() > 0 &&
                     !(angle_queue[0].drain_first && quat_expected.size() > 0)) begin
          s_tdata <= angle_queue[0].ang;
          angle_queue.pop_front();
          next_valid = 1'b1;
          send_gap <= pick_gap();
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // Monitor and receiver stalls.
  always @(posedge clk) begin
    quat_t got;
    quat_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap <= 0;
      calm_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = quat_t'(m_tdata);
        if (quat_expected.size() == 0) begin
          $error("unexpected transfer on output: %h", m_tdata);
          error_count++;
        end else begin
          want = quat_expected.pop_front();
          if (got.qw !== want.qw) begin
            $error("qw: expected %h, got %h", want.qw, got.qw); error_count++;
          end
          if (got.qx !== want.qx) begin
            $error("qx: expected %h, got %h", want.qx, got.qx); error_count++;
          end
          if (got.qy !== want.qy) begin
            $error("qy: expected %h, got %h", want.qy, got.qy); error_count++;
          end
          if (got.qz !== want.qz) begin
            $error("qz: expected %h, got %h", want.qz, got.qz); error_count++;
          end
        end
      end
      // Occasional stretches where neither side idles.
      if (calm_cycles > 0) begin
        calm_cycles <= calm_cycles - 1;
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 299) == 0) begin
        calm_cycles <= $urandom_range(50, 150);
        m_tready <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  initial begin
    logic [15:0] edges [6];
    error_count = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    edges = '{16'h0000, 16'h8000, 16'h7FFF, 16'h4000, 16'hC000, 16'hFFFF};

    add_angles(16'h0000, 16'h0000, 16'h0000, 1'b0);
    foreach (edges[i]) begin
      add_angles(edges[i], 16'h0000, 16'h0000, 1'b0);
      add_angles(16'h0000, edges[i], 16'h0000, 1'b0);
      add_angles(16'h0000, 16'h0000, edges[i], 1'b0);
    end
    add_angles(16'h8000, 16'h8000, 16'h8000, 1'b0);
    add_angles(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    add_angles(16'h5555, 16'hAAAA, 16'h2468, 1'b0);
    for (int n = 0; n < 1500; n++) begin
      if (n % 2 == 0)
        add_angles(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), n == 700);
      else
        add_angles(pick_angle(), pick_angle(), pick_angle(), n == 31);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    wait (angle_queue.size() == 0);
    @(posedge clk);
    while (s_tvalid || quat_expected.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0)
      $display("euler_to_quaternion_core regression: pass");
    else
      $display("euler_to_quaternion_core regression: fail");
    $finish;
  end

  initial begin
    #10000000;
    $display("euler_to_quaternion_core regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/eq_pkg.sv
rtl/eq_front.sv
rtl/eq_cordic.sv
rtl/eq_back.sv
rtl/euler_to_quaternion_core.sv
verif/testbench.sv
